FILE: rtl/pil_pkg.sv
// Shared types and constants for the positional insert/remove list.
`timescale 1ns / 1ps

package pil_pkg;

  // Default storage geometry.
  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths of the channel payloads.
  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int CAP_W    = 5;

  // Configuration register map.
  localparam int                 APB_ADDR_W = 3;
  localparam int                 APB_DATA_W = 32;
  localparam logic               REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_POS   = 3'd0,
    FN_INS_FRONT = 3'd1,
    FN_INS_END   = 3'd2,
    FN_REM_POS   = 3'd3,
    FN_REM_FRONT = 3'd4,
    FN_REM_END   = 3'd5
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Input beat.
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] new_key;
    logic [POS_W-1:0]        position;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] removed_key;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  // Decoded operation from the controller.
  typedef struct packed {
    logic ins_ok;
    logic rem_ok;
  } op_t;

  // Command broadcast along the cell chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

FILE: rtl/positional_insert_remove_list.sv
// Top level of the positional insert/remove list built as a chain of key cells.
//
//   Port group  Dir  Handshake          Beat
//   in_*        in   in_valid/in_stall  func, new_key, position
//   out_*       out  out_valid/out_stall status, removed_key, occupancy
//   APB         in   psel/penable/pready capacity register at byte address 0
//
// All cells shift in parallel, so the result is registered in the cycle after
// the input beat is taken, and a new beat is taken every cycle unless a held
// result is stalled by out_stall.
// Reset clears the fill count and sets capacity to 16; stored keys keep no reset.
// A held result stalls the input only while out_stall is high.
`timescale 1ns / 1ps

module positional_insert_remove_list #(
  parameter int DEPTH    = pil_pkg::DEPTH_DEF,
  parameter int KEY_BITS = pil_pkg::KEY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pil_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pil_pkg::out_item_t                 out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pil_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pil_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pil_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import pil_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           fill_nxt;
  logic [CAP_W-1:0]           cap_r;
  logic                       out_valid_r;
  out_item_t                  out_item_r;
  logic                       in_accept;
  op_t                        op;
  logic [STATUS_W-1:0]        status;
  logic [CNT_W-1:0]           pos_eff;
  cell_cmd_t                  cmd;
  logic signed [KEY_BITS-1:0] key_in;
  logic signed [KEY_BITS-1:0] cell_key [DEPTH];
  logic signed [KEY_BITS-1:0] sel_key;
  logic signed [KEY_W-1:0]    removed;
  logic                       cfg_wr;

  // Handshake.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_r) : '0;

  // Decode the beat against the current fill count.
  pil_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .func     (in_item.func),
    .position (in_item.position),
    .fill     (fill_r),
    .capacity (cap_r),
    .op       (op),
    .status   (status),
    .pos_eff  (pos_eff),
    .fill_nxt (fill_nxt)
  );

  // Command to the chain only for a taken beat that succeeds.
  assign cmd.ins = in_accept & op.ins_ok;
  assign cmd.rem = in_accept & op.rem_ok;
  assign key_in  = KEY_BITS'(in_item.new_key);

  // Chain of key cells; the ends see their own key.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [KEY_BITS-1:0] lower_key;
    logic signed [KEY_BITS-1:0] upper_key;
    if (g == 0) begin : g_lo_end
      assign lower_key = cell_key[g];
    end else begin : g_lo
      assign lower_key = cell_key[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi_end
      assign upper_key = cell_key[g];
    end else begin : g_hi
      assign upper_key = cell_key[g+1];
    end
    pil_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .IDX      (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos_eff),
      .new_key   (key_in),
      .lower_key (lower_key),
      .upper_key (upper_key),
      .key_r     (cell_key[g])
    );
  end

  // Key leaving on a remove; a valid remove target is always below DEPTH.
  assign sel_key = cell_key[pos_eff[IDX_W-1:0]];
  assign removed = op.rem_ok ? KEY_W'(sel_key) : '0;

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        fill_r <= fill_nxt;
      end
      if (cfg_wr) begin
        cap_r <= pwdata[CAP_W-1:0];
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item_r.status      <= status;
      out_item_r.removed_key <= removed;
      out_item_r.occupancy   <= OCC_W'(fill_nxt);
    end
  end

  // Fill count never exceeds the store.
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // A successful insert grows the count by one.
  assert property (@(posedge clk) disable iff (!rst_n)
      cmd.ins |=> fill_r == CNT_W'($past(fill_r) + 1'b1))
    else $error("insert did not grow fill count");

  // A refused beat leaves the count alone.
  assert property (@(posedge clk) disable iff (!rst_n)
      in_accept && (status != ST_DONE) |=> $stable(fill_r))
    else $error("refused beat changed fill count");

  // Only a completed remove reports a key.
  assert property (@(posedge clk) disable iff (!rst_n)
      in_accept && !op.rem_ok |=> out_item_r.removed_key == '0)
    else $error("removed key without a remove");

endmodule

FILE: rtl/pil_cell.sv
// One storage cell of the list chain: holds one key and trades with its neighbors.
`timescale 1ns / 1ps

module pil_cell #(
  parameter int KEY_BITS = 32,
  parameter int CNT_W    = 5,
  parameter int IDX      = 0
) (
  input  logic                       clk,
  input  pil_pkg::cell_cmd_t         cmd,
  input  logic [CNT_W-1:0]           pos,
  input  logic signed [KEY_BITS-1:0] new_key,
  input  logic signed [KEY_BITS-1:0] lower_key,
  input  logic signed [KEY_BITS-1:0] upper_key,
  output logic signed [KEY_BITS-1:0] key_r
);
  import pil_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic signed [KEY_BITS-1:0] key_nxt;

  // Insert: the target cell loads the key, cells above it take the lower neighbor.
  // Remove: the target cell and those above it take the upper neighbor.
  always_comb begin
    key_nxt = key_r;
    if (cmd.ins) begin
      if (MY_IDX == pos) begin
        key_nxt = new_key;
      end else if (MY_IDX > pos) begin
        key_nxt = lower_key;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= pos) begin
        key_nxt = upper_key;
      end
    end
  end

  // Key storage has no reset; entries at or above the fill count are never read.
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

FILE: rtl/pil_ctrl.sv
// Operation decode for the list: checks fullness, emptiness and position range.
`timescale 1ns / 1ps

module pil_ctrl #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  logic [pil_pkg::FUNC_W-1:0]   func,
  input  logic [pil_pkg::POS_W-1:0]    position,
  input  logic [CNT_W-1:0]             fill,
  input  logic [pil_pkg::CAP_W-1:0]    capacity,
  output pil_pkg::op_t                 op,
  output logic [pil_pkg::STATUS_W-1:0] status,
  output logic [CNT_W-1:0]             pos_eff,
  output logic [CNT_W-1:0]             fill_nxt
);
  import pil_pkg::*;

  // Compare width covers both the fill count and the 5-bit fields.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CMP_W-1:0] fill_w;
  logic [CMP_W-1:0] cap_w;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] depth_w;
  logic             is_full;
  logic             is_empty;

  assign fill_w   = CMP_W'(fill);
  assign cap_w    = CMP_W'(capacity);
  assign pos_w    = CMP_W'(position);
  assign depth_w  = CMP_W'(DEPTH);
  assign is_full  = (fill_w >= cap_w) || (fill_w >= depth_w);
  assign is_empty = (fill == '0);

  // Resolve the target index and the outcome of the operation.
  always_comb begin
    op      = '0;
    status  = ST_DONE;
    pos_eff = '0;
    case (func)
      FN_INS_POS, FN_INS_FRONT, FN_INS_END: begin
        if (is_full) begin
          status = ST_FULL;
        end else if (func == FN_INS_END) begin
          pos_eff   = fill;
          op.ins_ok = 1'b1;
        end else if (func == FN_INS_FRONT) begin
          op.ins_ok = 1'b1;
        end else if (pos_w > fill_w) begin
          status = ST_BADPOS;
        end else begin
          pos_eff   = CNT_W'(position);
          op.ins_ok = 1'b1;
        end
      end
      FN_REM_POS, FN_REM_FRONT, FN_REM_END: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (func == FN_REM_END) begin
          pos_eff   = fill - 1'b1;
          op.rem_ok = 1'b1;
        end else if (func == FN_REM_FRONT) begin
          op.rem_ok = 1'b1;
        end else if (pos_w >= fill_w) begin
          status = ST_BADPOS;
        end else begin
          pos_eff   = CNT_W'(position);
          op.rem_ok = 1'b1;
        end
      end
      default: begin
        // Unused codes change nothing and report done.
        status = ST_DONE;
      end
    endcase
  end

  // Count after the operation.
  always_comb begin
    fill_nxt = fill;
    if (op.ins_ok) begin
      fill_nxt = fill + 1'b1;
    end else if (op.rem_ok) begin
      fill_nxt = fill - 1'b1;
    end
  end

endmodule

FILE: dv/positional_insert_remove_list_tb.sv
// Self-checking testbench for the positional insert/remove list with a scoreboard class.
`timescale 1ns / 1ps

module positional_insert_remove_list_tb;
  import pil_pkg::*;

  localparam logic [FUNC_W-1:0]     FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0]     FN_SPARE_7 = 3'd7;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR   = APB_ADDR_W'(4 * REG_CAPACITY);
  localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
  localparam int                    SLOT_W     = $clog2(DEPTH_DEF);

  // Shadow copy of the list that predicts every result beat.
  class list_scoreboard;
    logic signed [KEY_W-1:0] slots [DEPTH_DEF];
    int unsigned             fill;
    int unsigned             capacity;
    out_item_t               expected_beats [$];
    int unsigned             fail_count;
    int unsigned             beats_checked;

    function new();
      fill          = 0;
      capacity      = CAP_RESET;
      fail_count    = 0;
      beats_checked = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    // Apply one operation to the shadow list and return the result it yields.
    function out_item_t apply_op(in_item_t op);
      out_item_t   res;
      int unsigned pos;
      int unsigned cap_eff;
      int unsigned i;
      res     = '0;
      cap_eff = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
      pos     = op.position;
      case (op.func)
        FN_INS_POS, FN_INS_FRONT, FN_INS_END: begin
          // Fullness wins over a bad position.
          if (fill >= cap_eff || fill >= DEPTH_DEF) begin
            res.status = ST_FULL;
          end else begin
            if (op.func == FN_INS_FRONT) pos = 0;
            else if (op.func == FN_INS_END) pos = fill;
            if (pos > fill) begin
              res.status = ST_BADPOS;
            end else begin
              for (i = fill; i > pos; i--) slots[SLOT_W'(i)] = slots[SLOT_W'(i-1)];
              slots[SLOT_W'(pos)] = op.new_key;
              fill++;
            end
          end
        end
        FN_REM_POS, FN_REM_FRONT, FN_REM_END: begin
          // Emptiness wins over a bad position.
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            if (op.func == FN_REM_FRONT) pos = 0;
            else if (op.func == FN_REM_END) pos = fill - 1;
            if (pos >= fill) begin
              res.status = ST_BADPOS;
            end else begin
              res.removed_key = slots[SLOT_W'(pos)];
              for (i = pos; i + 1 < fill; i++) slots[SLOT_W'(i)] = slots[SLOT_W'(i+1)];
              fill--;
            end
          end
        end
        default: ;
      endcase
      res.occupancy = OCC_W'(fill);
      return res;
    endfunction

    function void note_input(in_item_t op);
      expected_beats.push_back(apply_op(op));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: beat %0d %s: got %h, expected %h",
               $time, beats_checked, what, got, want);
      fail_count++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch("result with nothing pending", got.removed_key, '0);
      end else begin
        want = expected_beats.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.removed_key !== want.removed_key)
          report_mismatch("removed_key", got.removed_key, want.removed_key);
        if (got.occupancy !== want.occupancy)
          report_mismatch("occupancy", got.occupancy, want.occupancy);
      end
      beats_checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_beat = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_beat;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  list_scoreboard tracker = new();
  bit             tail_mode = 1'b0;
  int unsigned    cycle_count = 0;
  int unsigned    stall_left = 0;

  func_t ins_ops [3] = '{FN_INS_POS, FN_INS_FRONT, FN_INS_END};
  func_t rem_ops [3] = '{FN_REM_POS, FN_REM_FRONT, FN_REM_END};
  logic signed [KEY_W-1:0] edge_keys [4] = '{32'sd0, -32'sd1, KEY_MAX, KEY_MIN};

  positional_insert_remove_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Windows in which neither side idles.
  function automatic bit quiet_window();
    return tail_mode || ((cycle_count / 40) % 4 == 3);
  endfunction

  // Result side: check accepted beats and stall in random bursts.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_beat);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!quiet_window() && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one input beat, wait for it to be taken, then maybe idle.
  task automatic send_beat(input in_item_t op);
    in_beat  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.note_input(op);
    if (!quiet_window() && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] key,
                         input logic [POS_W-1:0] pos);
    in_item_t op;
    op.func     = f;
    op.new_key  = key;
    op.position = pos;
    send_beat(op);
  endtask

  // Stop offering beats and wait until every pending result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.expected_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic check_capacity_reg(input logic [CAP_W-1:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(want))
      tracker.report_mismatch("capacity readback", prdata, APB_DATA_W'(want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The readback that follows starts with its own setup cycle and drops pwrite.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_capacity(value);
    check_capacity_reg(value);
  endtask

  // Random operation, mostly with positions that land inside the list.
  function automatic in_item_t pick_op(int unsigned ins_pct);
    in_item_t    op;
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    if (roll < 2) op.func = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
    else if ($urandom_range(0, 99) < ins_pct) op.func = ins_ops[2'($urandom_range(0, 2))];
    else op.func = rem_ops[2'($urandom_range(0, 2))];
    if ($urandom_range(0, 9) == 0) op.new_key = edge_keys[2'($urandom_range(0, 3))];
    else op.new_key = $urandom;
    roll = $urandom_range(0, 99);
    if (op.func == FN_INS_POS) top = tracker.fill;
    else top = (tracker.fill == 0) ? 0 : tracker.fill - 1;
    if (roll < 70) op.position = POS_W'($urandom_range(0, top));
    else if (roll < 95) op.position = POS_W'($urandom_range(0, DEPTH_DEF));
    else op.position = POS_W'($urandom_range(0, 31));
    return op;
  endfunction

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned ins_pct,
                           input int unsigned count);
    write_capacity(cap);
    repeat (count) send_beat(pick_op(ins_pct));
    drain_results();
  endtask

  // Main sequence: reset, directed corner cases, then random phases.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_capacity_reg(CAP_RESET);

    // Small list: empty and full refusals, check order, bad positions, spare codes.
    write_capacity(5'd2);
    send_op(FN_REM_FRONT, 32'sd0, 5'd0);
    send_op(FN_REM_POS, 32'sd0, 5'd0);
    send_op(FN_REM_END, 32'sd0, 5'd31);
    send_op(FN_INS_POS, 32'sd5, 5'd1);
    send_op(FN_INS_POS, KEY_MAX, 5'd0);
    send_op(FN_INS_FRONT, KEY_MIN, 5'd16);
    send_op(FN_INS_END, -32'sd1, 5'd0);
    send_op(FN_INS_POS, 32'sd9, 5'd31);
    send_op(FN_SPARE_6, 32'sd3, 5'd0);
    send_op(FN_SPARE_7, -32'sd1, 5'd31);
    send_op(FN_REM_POS, 32'sd0, 5'd2);
    send_op(FN_REM_POS, 32'sd0, 5'd31);
    send_op(FN_REM_POS, 32'sd0, 5'd1);
    send_op(FN_REM_END, 32'sd0, 5'd0);
    send_op(FN_REM_FRONT, 32'sd0, 5'd0);
    drain_results();

    // Zero capacity refuses every insert.
    write_capacity(5'd0);
    send_op(FN_INS_POS, 32'sd1, 5'd0);
    send_op(FN_REM_END, 32'sd0, 5'd0);
    drain_results();

    // Capacity above the store size saturates.
    write_capacity(5'd31);
    send_op(FN_INS_END, KEY_MIN, 5'd0);
    send_op(FN_INS_END, KEY_MAX, 5'd0);
    send_op(FN_INS_POS, -32'sd1, 5'd1);
    drain_results();

    // Capacity lowered below the fill count: full, but removes still work.
    write_capacity(5'd1);
    send_op(FN_INS_FRONT, 32'sd7, 5'd0);
    send_op(FN_REM_POS, 32'sd0, 5'd1);
    send_op(FN_REM_FRONT, 32'sd0, 5'd0);
    drain_results();

    run_phase(5'd16, 80, 62);
    run_phase(5'd1, 50, 62);
    run_phase(5'd0, 50, 62);
    run_phase(5'd31, 75, 62);
    run_phase(5'd5, 60, 62);
    run_phase(5'd17, 40, 62);
    run_phase(5'd8, 65, 62);
    run_phase(5'd2, 50, 62);
    run_phase(5'd12, 45, 62);
    tail_mode = 1'b1;
    run_phase(5'd16, 55, 62);

    repeat (8) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
